@@ sv/keyboard_scancode_to_ascii_defines.svh @@
// Assertion helpers shared by the keyboard front end.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_DEFINES_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define KBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define KBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/kbd_pkg.sv @@
package kbd_pkg;

   typedef enum logic [1:0] {
      OP_EVENT = 2'd0,
      OP_TAKE  = 2'd1,
      OP_XLATE = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   localparam logic [7:0] KEY_RELEASE_BIT = 8'h80;
   localparam logic [6:0] KEY_LSHIFT      = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT      = 7'h36;
   localparam logic [6:0] KEY_CTRL        = 7'h1D;
   localparam logic [6:0] KEY_ALT         = 7'h38;
   localparam logic [6:0] KEY_CAPS        = 7'h3A;
   localparam logic [7:0] KEY_TABLE_LEN   = 8'h47;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  key_byte;
   } req_payload_type;

   typedef struct packed {
      logic [6:0]  code_out;
      logic [6:0]  char_out;
      logic        data_pending;
      logic        shift_held;
      logic        ctrl_held;
      logic        alt_held;
      logic        caps_on;
   } rsp_payload_type;

   typedef struct packed {
      logic shift;
      logic ctrl;
      logic alt;
      logic caps;
   } mod_flags_type;

   // Letter rows: q..p, a..l, z..m.
   function automatic logic is_letter(input logic [7:0] code);
      return (code inside {[8'h10:8'h19], [8'h1E:8'h26], [8'h2C:8'h32]});
   endfunction

   function automatic logic [6:0] plain_char(input logic [7:0] code);
      logic [6:0] ch;
      case (code)
         8'h02: ch = 7'h31;
         8'h03: ch = 7'h32;
         8'h04: ch = 7'h33;
         8'h05: ch = 7'h34;
         8'h06: ch = 7'h35;
         8'h07: ch = 7'h36;
         8'h08: ch = 7'h37;
         8'h09: ch = 7'h38;
         8'h0A: ch = 7'h39;
         8'h0B: ch = 7'h30;
         8'h0C: ch = 7'h2D;
         8'h0D: ch = 7'h3D;
         8'h0E: ch = 7'h08;
         8'h0F: ch = 7'h09;
         8'h10: ch = 7'h71;
         8'h11: ch = 7'h77;
         8'h12: ch = 7'h65;
         8'h13: ch = 7'h72;
         8'h14: ch = 7'h74;
         8'h15: ch = 7'h79;
         8'h16: ch = 7'h75;
         8'h17: ch = 7'h69;
         8'h18: ch = 7'h6F;
         8'h19: ch = 7'h70;
         8'h1A: ch = 7'h5B;
         8'h1B: ch = 7'h5D;
         8'h1C: ch = 7'h0A;
         8'h1E: ch = 7'h61;
         8'h1F: ch = 7'h73;
         8'h20: ch = 7'h64;
         8'h21: ch = 7'h66;
         8'h22: ch = 7'h67;
         8'h23: ch = 7'h68;
         8'h24: ch = 7'h6A;
         8'h25: ch = 7'h6B;
         8'h26: ch = 7'h6C;
         8'h27: ch = 7'h3B;
         8'h28: ch = 7'h27;
         8'h29: ch = 7'h60;
         8'h2B: ch = 7'h5C;
         8'h2C: ch = 7'h7A;
         8'h2D: ch = 7'h78;
         8'h2E: ch = 7'h63;
         8'h2F: ch = 7'h76;
         8'h30: ch = 7'h62;
         8'h31: ch = 7'h6E;
         8'h32: ch = 7'h6D;
         8'h33: ch = 7'h2C;
         8'h34: ch = 7'h2E;
         8'h35: ch = 7'h2F;
         8'h37: ch = 7'h2A;
         8'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] shift_char(input logic [7:0] code);
      logic [6:0] ch;
      case (code)
         8'h02: ch = 7'h21;
         8'h03: ch = 7'h40;
         8'h04: ch = 7'h23;
         8'h05: ch = 7'h24;
         8'h06: ch = 7'h25;
         8'h07: ch = 7'h5E;
         8'h08: ch = 7'h26;
         8'h09: ch = 7'h2A;
         8'h0A: ch = 7'h28;
         8'h0B: ch = 7'h29;
         8'h0C: ch = 7'h5F;
         8'h0D: ch = 7'h2B;
         8'h0E: ch = 7'h08;
         8'h0F: ch = 7'h09;
         8'h10: ch = 7'h51;
         8'h11: ch = 7'h57;
         8'h12: ch = 7'h45;
         8'h13: ch = 7'h52;
         8'h14: ch = 7'h54;
         8'h15: ch = 7'h59;
         8'h16: ch = 7'h55;
         8'h17: ch = 7'h49;
         8'h18: ch = 7'h4F;
         8'h19: ch = 7'h50;
         8'h1A: ch = 7'h7B;
         8'h1B: ch = 7'h7D;
         8'h1C: ch = 7'h0A;
         8'h1E: ch = 7'h41;
         8'h1F: ch = 7'h53;
         8'h20: ch = 7'h44;
         8'h21: ch = 7'h46;
         8'h22: ch = 7'h47;
         8'h23: ch = 7'h48;
         8'h24: ch = 7'h4A;
         8'h25: ch = 7'h4B;
         8'h26: ch = 7'h4C;
         8'h27: ch = 7'h3A;
         8'h28: ch = 7'h22;
         8'h29: ch = 7'h7E;
         8'h2B: ch = 7'h7C;
         8'h2C: ch = 7'h5A;
         8'h2D: ch = 7'h58;
         8'h2E: ch = 7'h43;
         8'h2F: ch = 7'h56;
         8'h30: ch = 7'h42;
         8'h31: ch = 7'h4E;
         8'h32: ch = 7'h4D;
         8'h33: ch = 7'h3C;
         8'h34: ch = 7'h3E;
         8'h35: ch = 7'h3F;
         8'h37: ch = 7'h2A;
         8'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ sv/kbd_chan_if.sv @@
interface kbd_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/kbd_xlate.sv @@
module kbd_xlate import kbd_pkg::*; (
   input  logic [7:0]    code,
   input  mod_flags_type flags,
   output logic [6:0]    ascii
);

   logic use_shift;

   // Letters follow shift xor caps lock, everything else shift alone.
   assign use_shift = is_letter(code) ? (flags.shift ^ flags.caps) : flags.shift;

   always_comb begin
      if (code >= KEY_TABLE_LEN) begin
         ascii = 7'h00;
      end else if (use_shift) begin
         ascii = shift_char(code);
      end else begin
         ascii = plain_char(code);
      end
   end

endmodule

@@ sv/kbd_core.sv @@
`include "keyboard_scancode_to_ascii_defines.svh"

module kbd_core import kbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  op_type          opcode,
   input  logic [7:0]      key_byte,
   output rsp_payload_type result
);

   logic [6:0]    pending_ff;
   logic [6:0]    pending_in;
   mod_flags_type flags_ff;
   mod_flags_type flags_in;
   logic [7:0]    xlate_code;
   logic [6:0]    xlate_char;
   logic [6:0]    key_code;

   assign key_code = key_byte[6:0];

   // Take translates the pending code, translate uses the given byte.
   assign xlate_code = (opcode == OP_TAKE) ? {1'b0, pending_ff} : key_byte;

   kbd_xlate u_xlate (
      .code  (xlate_code),
      .flags (flags_ff),
      .ascii (xlate_char)
   );

   always_comb begin
      pending_in = pending_ff;
      flags_in   = flags_ff;
      case (opcode)
         OP_EVENT: begin
            if ((key_byte & KEY_RELEASE_BIT) != 8'h00) begin
               if (key_code == KEY_LSHIFT || key_code == KEY_RSHIFT) begin
                  flags_in.shift = 1'b0;
               end else if (key_code == KEY_CTRL) begin
                  flags_in.ctrl = 1'b0;
               end else if (key_code == KEY_ALT) begin
                  flags_in.alt = 1'b0;
               end
            end else begin
               pending_in = key_code;
               if (key_code == KEY_LSHIFT || key_code == KEY_RSHIFT) begin
                  flags_in.shift = 1'b1;
               end else if (key_code == KEY_CTRL) begin
                  flags_in.ctrl = 1'b1;
               end else if (key_code == KEY_ALT) begin
                  flags_in.alt = 1'b1;
               end else if (key_code == KEY_CAPS) begin
                  flags_in.caps = ~flags_ff.caps;
               end
            end
         end
         OP_TAKE: begin
            pending_in = 7'h00;
         end
         OP_XLATE: begin
            pending_in = pending_ff;
         end
         OP_FLUSH: begin
            pending_in = 7'h00;
            flags_in   = '0;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_comb begin
      result.code_out     = pending_ff;
      result.char_out     = (opcode == OP_TAKE || opcode == OP_XLATE) ? xlate_char : 7'h00;
      result.data_pending = (pending_in != 7'h00);
      result.shift_held   = flags_in.shift;
      result.ctrl_held    = flags_in.ctrl;
      result.alt_held     = flags_in.alt;
      result.caps_on      = flags_in.caps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 7'h00;
         flags_ff   <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         flags_ff   <= flags_in;
      end
   end

   `KBD_ASSERT_NEXT(a_flush_clears, clock, reset, advance && opcode == OP_FLUSH, pending_ff == 7'h00 && flags_ff == '0, "flush left state behind")
   `KBD_ASSERT_NEXT(a_xlate_keeps, clock, reset, advance && opcode == OP_XLATE, $stable(pending_ff) && $stable(flags_ff), "translate changed state")
   `KBD_ASSERT_NEXT(a_idle_keeps, clock, reset, !advance, $stable(pending_ff) && $stable(flags_ff), "state moved without a beat")

endmodule

@@ sv/keyboard_scancode_to_ascii.sv @@
// An accepted req beat passes through the input register and then the result register before its rsp beat.
// Throughput: one beat per cycle while rsp_chan.ready holds; both sides may then stream back to back without bubbles.
// Every beat goes through the same flag update and table lookup.
// Reset (synchronous, active high) clears the pending code, the four modifier flags
// and both stage valids; the payload registers are not reset.
`include "keyboard_scancode_to_ascii_defines.svh"

module keyboard_scancode_to_ascii import kbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kbd_chan_if.sink    req_chan,
   kbd_chan_if.source  rsp_chan
);

   // Input stage: holds one req beat until the result stage can take it.
   logic            in_valid_ff;
   logic            in_valid_in;
   op_type          in_opcode_ff;
   logic [7:0]      in_byte_ff;

   // Result stage: the output register seen on the rsp channel.
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type core_result;

   logic            out_free;
   logic            advance;
   logic            in_load;

   // The result register frees up when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // Move the held beat forward (and commit its state change) when there is room.
   assign advance  = in_valid_ff && out_free;
   // Take a new beat if the input register is empty or drains this cycle.
   assign req_chan.ready = !in_valid_ff || out_free;
   assign in_load  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load only, no reset.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_opcode_ff <= req_chan.payload.opcode;
         in_byte_ff   <= req_chan.payload.key_byte;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   // Modifier flags, pending code, and the translation lookup.
   kbd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .opcode   (in_opcode_ff),
      .key_byte (in_byte_ff),
      .result   (core_result)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `KBD_ASSERT_IMPLY(a_advance_needs_item, clock, reset, advance, in_valid_ff, "advance with empty input stage")
   `KBD_ASSERT_IMPLY(a_rsp_rose_from_item, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff), "result appeared without an input beat")
   `KBD_ASSERT_NEXT(a_stall_holds_item, clock, reset, in_valid_ff && !out_free, in_valid_ff, "input beat lost during stall")

endmodule
